@@ rtl/mavg_pkg.sv @@
// Shared types and constants for the moving average filter.
package mavg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 24;
  localparam int FRAC_W   = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_LOAD,
    S_DIV,
    S_OUT
  } mavg_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic sum_step;
    logic div_load;
    logic div_step;
    logic out_load;
  } mavg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sum_last;
    logic div_last;
    logic out_free;
  } mavg_status_t;

endpackage

@@ rtl/mavg_ctrl.sv @@
// Sequencer for the moving average filter: accept, sum, divide, emit.
module mavg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  output mavg_pkg::mavg_cmd_t    cmd,
  input  mavg_pkg::mavg_status_t status
);
  import mavg_pkg::*;

  mavg_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SUM;
      end
      S_SUM: begin
        if (status.sum_last) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (status.div_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_SUM:  cmd.sum_step = 1'b1;
      S_LOAD: cmd.div_load = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_OUT:  cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/mavg_dp.sv @@
// Datapath: sample window, running sum, restoring divider and output register.
module mavg_dp #(
  parameter int WINDOW_LEN = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [mavg_pkg::SAMPLE_W-1:0]  sample,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mavg_pkg::MEAN_W-1:0]    mean_value,
  input  mavg_pkg::mavg_cmd_t            cmd,
  output mavg_pkg::mavg_status_t         status
);
  import mavg_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN) + 1;
  localparam int DVD_W = SUM_W + FRAC_W;
  localparam int DC_W  = $clog2(DVD_W);

  logic [SAMPLE_W-1:0] window_r [WINDOW_LEN];
  logic [IDX_W-1:0]    wr_pos_r;
  logic [CNT_W-1:0]    fill_r;
  logic [IDX_W-1:0]    idx_r;
  logic [SUM_W-1:0]    sum_r;
  logic                neg_r;
  logic [DVD_W-1:0]    quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic [DC_W-1:0]     div_cnt_r;
  logic                out_valid_r;
  logic [MEAN_W-1:0]   out_data_r;

  logic [CNT_W-1:0]    fill_m1;
  logic [SAMPLE_W-1:0] rd_sample;
  logic [SUM_W-1:0]    sum_nxt;
  logic [SUM_W-1:0]    sum_mag;
  logic [CNT_W:0]      trial;
  logic                trial_ge;
  logic [DVD_W-1:0]    quo_signed;

  assign fill_m1   = fill_r - CNT_W'(1);
  assign rd_sample = window_r[idx_r];
  assign sum_nxt   = sum_r + {{(SUM_W-SAMPLE_W){rd_sample[SAMPLE_W-1]}}, rd_sample};
  assign sum_mag   = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
  assign trial     = {rem_r, quo_r[DVD_W-1]};
  assign trial_ge  = (trial >= {1'b0, fill_r});
  assign quo_signed = neg_r ? (~quo_r + DVD_W'(1)) : quo_r;

  assign status.sum_last = (idx_r == fill_m1[IDX_W-1:0]);
  assign status.div_last = (div_cnt_r == DC_W'(DVD_W - 1));
  assign status.out_free = !out_valid_r || out_tready;

  // Window store: written once per accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) window_r[wr_pos_r] <= sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
      fill_r   <= '0;
    end else if (cmd.accept) begin
      wr_pos_r <= (wr_pos_r == IDX_W'(WINDOW_LEN - 1)) ? '0 : wr_pos_r + IDX_W'(1);
      if (fill_r != CNT_W'(WINDOW_LEN)) fill_r <= fill_r + CNT_W'(1);
    end
  end

  // Sum valid slots 0 .. fill-1, one per cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= '0;
      sum_r <= '0;
    end else if (cmd.sum_step) begin
      idx_r <= idx_r + IDX_W'(1);
      sum_r <= sum_nxt;
    end
  end

  // Restoring divide of |sum| * 256 by the fill count, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r     <= sum_r[SUM_W-1];
      quo_r     <= {sum_mag, {FRAC_W{1'b0}}};
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DC_W'(1);
      if (trial_ge) begin
        rem_r <= CNT_W'(trial - {1'b0, fill_r});
        quo_r <= {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[CNT_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  // Output register: holds a finished item while the next one is worked on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= quo_signed[MEAN_W-1:0];
  end

  assign out_tvalid = out_valid_r;
  assign mean_value = out_data_r;

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while occupied");

  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |=> (div_cnt_r == '0 && rem_r == '0))
    else $error("divider not restarted on load");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= CNT_W'(WINDOW_LEN)) && (wr_pos_r <= IDX_W'(WINDOW_LEN - 1)))
    else $error("fill count or write slot out of range");

  a_sum_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_step |-> (fill_r != '0))
    else $error("sum started on an empty window");

endmodule

@@ rtl/moving_average_filter.sv @@
// Top level of the moving average filter.
// Each accepted item carries one signed 16-bit sample; the block stores it in a
// window of the last WINDOW_LEN samples and returns one item holding the mean of
// the samples held so far (divisor is the fill count during warm-up), as a signed
// 24-bit value with 8 fraction bits, truncated toward zero. The window is summed
// one entry per cycle and the mean comes from a restoring divider that produces
// one quotient bit per cycle. One item is worked on at a time; a finished
// result waits in an output register, so the next item is taken while the
// previous result is still pending.
module moving_average_filter #(
  parameter int WINDOW_LEN = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [23:0] mean_value
);
  import mavg_pkg::*;

  mavg_cmd_t    cmd;
  mavg_status_t status;

  mavg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .status    (status)
  );

  mavg_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .sample     (in_tdata[SAMPLE_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .mean_value (out_tdata[MEAN_W-1:0]),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the moving average filter.
`timescale 1ns / 100ps

module testbench;

  import mavg_pkg::*;

  localparam int WIN_LEN     = 3;
  localparam int LONG_HOLD   = 300;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CHUNK       = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [MEAN_W-1:0] out_tdata;

  moving_average_filter #(.WINDOW_LEN(WIN_LEN)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predicted filter state
  logic signed [SAMPLE_W-1:0] win_samples [WIN_LEN];
  int win_wr_pos = 0;
  int win_fill   = 0;

  logic [SAMPLE_W-1:0] sample_q [$];
  logic [MEAN_W-1:0]   mean_q [$];

  int  fail_count = 0;
  bit  burst_mode = 1'b0;
  bit  tx_drain_wait = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  rx_hold = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  logic [MEAN_W-1:0] mean_exp;

  // Push one sample into the window and return the truncated 8-fraction-bit mean.
  function automatic logic [MEAN_W-1:0] window_mean(logic signed [SAMPLE_W-1:0] s);
    longint acc;
    longint quot;
    acc = 0;
    win_samples[win_wr_pos] = s;
    win_wr_pos = (win_wr_pos + 1 >= WIN_LEN) ? 0 : win_wr_pos + 1;
    if (win_fill < WIN_LEN) win_fill++;
    for (int i = 0; i < win_fill; i++) acc += win_samples[i];
    // longint division rounds toward zero
    quot = (acc * 256) / win_fill;
    return quot[MEAN_W-1:0];
  endfunction

  // Append one sample to the pending items.
  function automatic void add_sample(logic [SAMPLE_W-1:0] v);
    sample_q.insert(sample_q.size(), v);
  endfunction

  // Mostly short gaps, now and then a long one; none in burst mode.
  function automatic int idle_len();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'h8000;
    if (r < 8) return 16'h7fff;
    if (r < 10) return 16'h0000;
    if (r < 12) return 16'hffff;
    if (r < 22) return SAMPLE_W'($urandom_range(0, 8) - 4);
    return SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  // Sender: hold the item until accepted, then idle or send the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) mean_q.insert(mean_q.size(), window_mean(in_tdata));
      if (!(in_tvalid && !in_tready)) begin
        if (tx_drain_wait && mean_q.size() == 0) tx_drain_wait = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (tx_drain_wait || sample_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= sample_q[0];
          sample_q.delete(0);
          tx_gap = idle_len();
          // occasionally stop until every pending mean has come back
          if (!burst_mode && $urandom_range(0, 99) == 0) tx_drain_wait = 1'b1;
        end
      end
    end
  end

  // Receiver: check each accepted item against the oldest predicted mean.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (mean_q.size() == 0) begin
          $error("unexpected item: mean_value actual %0d", $signed(out_tdata));
          fail_count++;
        end else begin
          mean_exp = mean_q[0];
          mean_q.delete(0);
          if (out_tdata !== mean_exp) begin
            $error("mean_value mismatch: expected %0d, actual %0d",
                   $signed(mean_exp), $signed(out_tdata));
            fail_count++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        rx_hold = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_gap = idle_len();
      end
    end
  end

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_tvalid || mean_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Warm-up at the negative extreme, then full window at both extremes
    add_sample(16'h8000);
    add_sample(16'h8000);
    add_sample(16'h8000);
    add_sample(16'h7fff);
    add_sample(16'h7fff);
    add_sample(16'h7fff);
    // Negative and positive thirds: truncate toward zero
    add_sample(16'hffff);
    add_sample(16'h0000);
    add_sample(16'h0000);
    add_sample(16'h0001);
    add_sample(16'h0000);
    add_sample(16'hfffe);
    add_sample(16'hffff);
    // Mixed extremes across the window
    add_sample(16'h7fff);
    add_sample(16'h8000);
    add_sample(16'h8000);
    add_sample(16'h7fff);
    add_sample(16'h5555);
    add_sample(16'haaaa);
    add_sample(16'h0000);
    wait_drained();

    // Stall the receiver for a long stretch while items keep coming
    burst_mode = 1'b1;
    hold_req++;
    for (int i = 0; i < 20; i++) add_sample(rand_sample());
    wait_drained();
    burst_mode = 1'b0;

    for (int c = 0; c < RANDOM_ITEMS / CHUNK; c++) begin
      burst_mode = (c % 3 == 1);
      for (int i = 0; i < CHUNK; i++) add_sample(rand_sample());
      while (sample_q.size() != 0) @(posedge clk);
      if (c == 5) hold_req++;
    end
    wait_drained();
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
